// File: src/max_flow_dinic_assert.svh
// Assertion macros used by the block's controller module.
// Both macros sample on clk and are switched off while arst_n is low.
`ifndef MAX_FLOW_DINIC_ASSERT_SVH
`define MAX_FLOW_DINIC_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define MFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define MFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/mfd_pkg.sv
package mfd_pkg;

	// Graph sizing
	localparam int NODES     = 128;
	localparam int MAX_EDGES = 256;
	localparam int ARCS      = 4 * MAX_EDGES;
	localparam int NODE_W    = $clog2(NODES);
	localparam int ARC_W     = $clog2(ARCS);
	localparam int ARCP_W    = ARC_W + 1;
	localparam int DEPTH_W   = NODE_W + 1;
	localparam int LVL_W     = 8;
	localparam int CAP_W     = 24;
	localparam int FLOW_W    = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [ARCP_W-1:0] ARC_NONE   = ARCP_W'(ARCS);
	localparam logic [ARCP_W-1:0] ARC_LIMIT  = ARCP_W'(ARCS - 4);
	localparam logic [LVL_W-1:0]  LEVEL_NONE = '1;
	localparam logic [NODE_W-1:0] SOURCE_RESET = NODE_W'(65);
	localparam logic [NODE_W-1:0] SINK_RESET   = NODE_W'(90);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SINK   = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE, ST_LOAD, ST_OVF, ST_ARC_RD, ST_ARC_WR,
		ST_BFS_INIT, ST_BFS_POP, ST_BFS_X, ST_BFS_HEAD, ST_BFS_ARC, ST_BFS_CHK,
		ST_DFS_INIT, ST_DFS_NODE, ST_DFS_RES, ST_DFS_SCAN, ST_DFS_TEST, ST_DFS_CMP,
		ST_DFS_FOUND, ST_DFS_STOP, ST_DFS_POP, ST_DFS_POP2, ST_DFS_POP3,
		ST_DFS_ADV, ST_DFS_ADV2, ST_DFS_ADV3,
		ST_AUG_INIT, ST_AM_RD, ST_AM_ARC, ST_AM_CMP,
		ST_AU_RD, ST_AU_A, ST_AU_SUB, ST_AU_ADD, ST_AUG_END, ST_FIN
	} state_t;

	typedef enum logic [5:0] {
		OP_NOP, OP_OVF, OP_ARC_RD, OP_ARC_WR,
		OP_BFS_INIT, OP_BFS_POP, OP_BFS_X, OP_BFS_HEAD, OP_BFS_ARC, OP_BFS_CHK,
		OP_DFS_INIT, OP_DFS_NODE, OP_DFS_RES, OP_DFS_SCAN, OP_DFS_TEST, OP_DFS_CMP,
		OP_DFS_FOUND, OP_DFS_STOP, OP_DFS_POP, OP_DFS_POP2, OP_DFS_POP3,
		OP_DFS_ADV, OP_DFS_ADV2, OP_DFS_ADV3,
		OP_AUG_INIT, OP_AM_RD, OP_AM_ARC, OP_AM_CMP,
		OP_AU_RD, OP_AU_A, OP_AU_SUB, OP_AU_ADD, OP_AUG_END, OP_FIN
	} op_t;

	typedef struct packed {
		op_t  op;
		logic take;
	} cmd_t;

	typedef struct packed {
		logic arc_full;
		logic last;
		logic src_eq_dst;
		logic j_last;
		logic q_empty;
		logic dst_reached;
		logic a_none;
		logic at_dst;
		logic found;
		logic depth_full;
		logic depth_zero;
		logic cur_none;
		logic i_last;
		logic out_busy;
	} sts_t;

endpackage

// File: src/max_flow_dinic.sv
// Maximum-flow engine, Dinic's method, over an undirected capacitated graph.
// Edge channel: edge_valid/edge_stall carry from_node, to_node, capacity and
// last. Each request loads one edge as four arcs into the adjacency tables;
// arcs are written one after another, bounded by the single write port of the
// arc and list memories; the edge is dropped when the 1024-arc table is full.
// The request with last set is loaded, then, unless source equals sink, level
// building and blocking-flow search run; their length depends on the graph.
// Result channel: result_valid/result_stall carry max_flow and edges_dropped,
// one result per request with last set. The result sits in an output
// register, the graph is cleared at once and new edges are taken while the
// result waits; a second result waits until the first has been taken.
// Configuration: cfg_valid/cfg_ready, cfg_index (0 source, 1 sink), cfg_data;
// always ready; written by the user only while the block is idle (unchecked).
// Reset: source 65, sink 90, graph empty, no result pending. No clearing pass.
module max_flow_dinic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mfd_pkg::NODE_W-1:0]    cfg_data,
	input  logic                          edge_valid,
	output logic                          edge_stall,
	input  logic [mfd_pkg::NODE_W-1:0]    from_node,
	input  logic [mfd_pkg::NODE_W-1:0]    to_node,
	input  logic [mfd_pkg::CAP_W-1:0]     capacity,
	input  logic                          last,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [mfd_pkg::FLOW_W-1:0]    max_flow,
	output logic                          edges_dropped
);
	import mfd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	mfd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.edge_valid (edge_valid),
		.edge_stall (edge_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	mfd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.from_node     (from_node),
		.to_node       (to_node),
		.capacity      (capacity),
		.last          (last),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.max_flow      (max_flow),
		.edges_dropped (edges_dropped)
	);

endmodule

// File: src/mfd_ctrl.sv
`include "max_flow_dinic_assert.svh"

module mfd_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         edge_valid,
	output logic         edge_stall,
	input  mfd_pkg::sts_t sts,
	output mfd_pkg::cmd_t cmd
);
	import mfd_pkg::*;

	state_t state_q, state_d, after_load;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d    = state_q;
		cmd.op     = OP_NOP;
		cmd.take   = 1'b0;
		edge_stall = (state_q != ST_IDLE);
		// where to go once the edge is in the tables
		if (!sts.last) begin
			after_load = ST_IDLE;
		end else if (sts.src_eq_dst) begin
			after_load = ST_FIN;
		end else begin
			after_load = ST_BFS_INIT;
		end
		case (state_q)
			ST_IDLE: begin
				if (edge_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_LOAD;
				end
			end
			ST_LOAD:   state_d = sts.arc_full ? ST_OVF : ST_ARC_RD;
			ST_OVF: begin
				cmd.op  = OP_OVF;
				state_d = after_load;
			end
			ST_ARC_RD: begin
				cmd.op  = OP_ARC_RD;
				state_d = ST_ARC_WR;
			end
			ST_ARC_WR: begin
				cmd.op  = OP_ARC_WR;
				state_d = sts.j_last ? after_load : ST_ARC_RD;
			end
			// level building
			ST_BFS_INIT: begin
				cmd.op  = OP_BFS_INIT;
				state_d = ST_BFS_POP;
			end
			ST_BFS_POP: begin
				if (sts.q_empty) begin
					state_d = sts.dst_reached ? ST_DFS_INIT : ST_FIN;
				end else begin
					cmd.op  = OP_BFS_POP;
					state_d = ST_BFS_X;
				end
			end
			ST_BFS_X: begin
				cmd.op  = OP_BFS_X;
				state_d = ST_BFS_HEAD;
			end
			ST_BFS_HEAD: begin
				cmd.op  = OP_BFS_HEAD;
				state_d = ST_BFS_ARC;
			end
			ST_BFS_ARC: begin
				cmd.op  = OP_BFS_ARC;
				state_d = sts.a_none ? ST_BFS_POP : ST_BFS_CHK;
			end
			ST_BFS_CHK: begin
				cmd.op  = OP_BFS_CHK;
				state_d = ST_BFS_ARC;
			end
			// blocking flow search
			ST_DFS_INIT: begin
				cmd.op  = OP_DFS_INIT;
				state_d = ST_DFS_NODE;
			end
			ST_DFS_NODE: begin
				if (sts.at_dst) begin
					state_d = ST_AUG_INIT;
				end else begin
					cmd.op  = OP_DFS_NODE;
					state_d = ST_DFS_RES;
				end
			end
			ST_DFS_RES: begin
				cmd.op  = OP_DFS_RES;
				state_d = ST_DFS_SCAN;
			end
			ST_DFS_SCAN: begin
				cmd.op  = OP_DFS_SCAN;
				state_d = sts.a_none ? ST_DFS_STOP : ST_DFS_TEST;
			end
			ST_DFS_TEST: begin
				cmd.op  = OP_DFS_TEST;
				state_d = ST_DFS_CMP;
			end
			ST_DFS_CMP: begin
				cmd.op  = OP_DFS_CMP;
				state_d = sts.found ? ST_DFS_FOUND : ST_DFS_SCAN;
			end
			ST_DFS_FOUND: begin
				cmd.op  = OP_DFS_FOUND;
				state_d = sts.depth_full ? ST_DFS_POP : ST_DFS_NODE;
			end
			ST_DFS_STOP: begin
				cmd.op  = OP_DFS_STOP;
				state_d = sts.depth_zero ? ST_BFS_INIT : ST_DFS_POP;
			end
			ST_DFS_POP: begin
				cmd.op  = OP_DFS_POP;
				state_d = ST_DFS_POP2;
			end
			ST_DFS_POP2: begin
				cmd.op  = OP_DFS_POP2;
				state_d = ST_DFS_POP3;
			end
			ST_DFS_POP3: begin
				cmd.op  = OP_DFS_POP3;
				state_d = ST_DFS_ADV;
			end
			ST_DFS_ADV: begin
				cmd.op  = OP_DFS_ADV;
				state_d = ST_DFS_ADV2;
			end
			ST_DFS_ADV2: begin
				cmd.op  = OP_DFS_ADV2;
				state_d = sts.cur_none ? ST_DFS_NODE : ST_DFS_ADV3;
			end
			ST_DFS_ADV3: begin
				cmd.op  = OP_DFS_ADV3;
				state_d = ST_DFS_NODE;
			end
			// augmentation: bottleneck pass, then update pass
			ST_AUG_INIT: begin
				cmd.op  = OP_AUG_INIT;
				state_d = ST_AM_RD;
			end
			ST_AM_RD: begin
				cmd.op  = OP_AM_RD;
				state_d = ST_AM_ARC;
			end
			ST_AM_ARC: begin
				cmd.op  = OP_AM_ARC;
				state_d = ST_AM_CMP;
			end
			ST_AM_CMP: begin
				cmd.op  = OP_AM_CMP;
				state_d = sts.i_last ? ST_AU_RD : ST_AM_RD;
			end
			ST_AU_RD: begin
				cmd.op  = OP_AU_RD;
				state_d = ST_AU_A;
			end
			ST_AU_A: begin
				cmd.op  = OP_AU_A;
				state_d = ST_AU_SUB;
			end
			ST_AU_SUB: begin
				cmd.op  = OP_AU_SUB;
				state_d = ST_AU_ADD;
			end
			ST_AU_ADD: begin
				cmd.op  = OP_AU_ADD;
				state_d = sts.i_last ? ST_AUG_END : ST_AU_RD;
			end
			ST_AUG_END: begin
				cmd.op  = OP_AUG_END;
				state_d = ST_DFS_NODE;
			end
			// hand over the result and clear the graph
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.op  = OP_FIN;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`MFD_ASSERT_NEXT(a_take_load, edge_valid && !edge_stall, state_q == ST_LOAD,
		"accepted request did not start loading")
	`MFD_ASSERT_NEXT(a_fin_idle, state_q == ST_FIN && !sts.out_busy, state_q == ST_IDLE,
		"result hand-over did not return to idle")
	`MFD_ASSERT_NOW(a_fin_free, cmd.op == OP_FIN, !sts.out_busy,
		"result written over a waiting result")

endmodule

// File: src/mfd_dp.sv
module mfd_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mfd_pkg::cmd_t                      cmd,
	output mfd_pkg::sts_t                      sts,
	input  logic                               cfg_valid,
	input  logic [mfd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mfd_pkg::NODE_W-1:0]         cfg_data,
	input  logic [mfd_pkg::NODE_W-1:0]         from_node,
	input  logic [mfd_pkg::NODE_W-1:0]         to_node,
	input  logic [mfd_pkg::CAP_W-1:0]          capacity,
	input  logic                               last,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [mfd_pkg::FLOW_W-1:0]         max_flow,
	output logic                               edges_dropped
);
	import mfd_pkg::*;

	// Configuration and latched request
	logic [NODE_W-1:0] src_q, dst_q, f_q, t_q;
	logic [CAP_W-1:0]  cap_q;
	logic              last_q;

	// Control state
	logic [ARCP_W-1:0]  arc_cnt_q;
	logic               ovf_q;
	logic [1:0]         j_q;
	logic [NODES-1:0]   hv_q, lv_q, rv_q;
	logic [DEPTH_W-1:0] rd_q, wr_q, depth_q, i_q;
	logic [FLOW_W-1:0]  total_q;
	logic               res_valid_q;
	logic [FLOW_W-1:0]  flow_q;
	logic               drop_q;

	// Working registers
	logic [NODE_W-1:0] x_q, node_q;
	logic [LVL_W-1:0]  xl_q, nlvl_q;
	logic [ARCP_W-1:0] a_q;
	logic [CAP_W-1:0]  bott_q;

	// Memories and their read registers
	logic [NODE_W-1:0] dest_mem  [ARCS];
	logic [CAP_W-1:0]  res_mem   [ARCS];
	logic [ARCP_W-1:0] next_mem  [ARCS];
	logic [ARCP_W-1:0] head_mem  [NODES];
	logic [ARCP_W-1:0] tail_mem  [NODES];
	logic [LVL_W-1:0]  lvl_mem   [NODES];
	logic [ARCP_W-1:0] resm_mem  [NODES];
	logic [NODE_W-1:0] queue_mem [NODES];
	logic [ARC_W-1:0]  stack_mem [NODES];

	logic [NODE_W-1:0] dest_rd, queue_rd;
	logic [CAP_W-1:0]  res_rd;
	logic [ARCP_W-1:0] next_rd, head_rd, tail_rd, resm_rd;
	logic [LVL_W-1:0]  lvl_rd;
	logic [ARC_W-1:0]  stack_rd;

	// Combinational helpers
	logic [NODE_W-1:0]  u_node, w_node, node_ra, lvl_ra;
	logic [CAP_W-1:0]   cap_j;
	logic [ARC_W-1:0]   arc_k, dest_ra, res_ra, next_ra;
	logic [ARCP_W-1:0]  node_arc;
	logic [LVL_W-1:0]   lvl_y, nlvl_inc;
	logic [DEPTH_W-1:0] depth_dec, i_inc;
	logic               bfs_take, found, depth_full;
	logic               dest_re, res_re, next_re, head_re, lvl_re, stack_re;
	logic [NODE_W-1:0]  stack_ra;

	// Arc being loaded: forward, its reverse, back arc, its reverse
	assign u_node = (j_q == 2'd0 || j_q == 2'd3) ? f_q : t_q;
	assign w_node = (j_q == 2'd0 || j_q == 2'd3) ? t_q : f_q;
	assign cap_j  = j_q[0] ? '0 : cap_q;
	assign arc_k  = arc_cnt_q[ARC_W-1:0];

	// Current resume arc of node_q (falls back to the list head)
	assign node_arc = rv_q[node_q] ? resm_rd : (hv_q[node_q] ? head_rd : ARC_NONE);

	assign nlvl_inc   = nlvl_q + LVL_W'(1);
	assign lvl_y      = lv_q[dest_rd] ? lvl_rd : LEVEL_NONE;
	assign found      = (lvl_y == nlvl_inc) && (res_rd != '0);
	assign bfs_take   = !lv_q[dest_rd] && (res_rd != '0) && (wr_q < DEPTH_W'(NODES));
	assign depth_full = (depth_q >= DEPTH_W'(NODES));
	assign depth_dec  = depth_q - DEPTH_W'(1);
	assign i_inc      = i_q + DEPTH_W'(1);

	// Read address selection
	always_comb begin
		dest_re  = 1'b0;
		res_re   = 1'b0;
		next_re  = 1'b0;
		head_re  = 1'b0;
		lvl_re   = 1'b0;
		stack_re = 1'b0;
		dest_ra  = a_q[ARC_W-1:0];
		res_ra   = a_q[ARC_W-1:0];
		next_ra  = a_q[ARC_W-1:0];
		node_ra  = node_q;
		lvl_ra   = node_q;
		stack_ra = i_q[NODE_W-1:0];
		case (cmd.op)
			OP_ARC_RD: begin
				head_re = 1'b1;
				node_ra = u_node;
			end
			OP_BFS_X: begin
				head_re = 1'b1;
				lvl_re  = 1'b1;
				node_ra = queue_rd;
				lvl_ra  = queue_rd;
			end
			OP_BFS_ARC, OP_DFS_SCAN: begin
				dest_re = 1'b1;
				res_re  = 1'b1;
				next_re = 1'b1;
			end
			OP_DFS_NODE: begin
				head_re = 1'b1;
				lvl_re  = 1'b1;
			end
			OP_DFS_ADV: head_re = 1'b1;
			OP_DFS_TEST: begin
				lvl_re = 1'b1;
				lvl_ra = dest_rd;
			end
			OP_DFS_POP: begin
				stack_re = 1'b1;
				stack_ra = depth_dec[NODE_W-1:0];
			end
			OP_DFS_POP2: begin
				dest_re = 1'b1;
				dest_ra = stack_rd ^ ARC_W'(1);
			end
			OP_DFS_ADV2: begin
				next_re = 1'b1;
				next_ra = node_arc[ARC_W-1:0];
			end
			OP_AM_RD, OP_AU_RD: stack_re = 1'b1;
			OP_AM_ARC, OP_AU_A: begin
				res_re = 1'b1;
				res_ra = stack_rd;
			end
			OP_AU_SUB: begin
				res_re = 1'b1;
				res_ra = a_q[ARC_W-1:0] ^ ARC_W'(1);
			end
			default: ;
		endcase
	end

	// Arc tables
	always_ff @(posedge clk) begin
		if (cmd.op == OP_ARC_RD) begin
			dest_mem[arc_k] <= w_node;
		end
		if (dest_re) begin
			dest_rd <= dest_mem[dest_ra];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ARC_RD: res_mem[arc_k] <= cap_j;
			OP_AU_SUB: res_mem[a_q[ARC_W-1:0]] <= res_rd - bott_q;
			OP_AU_ADD: res_mem[a_q[ARC_W-1:0] ^ ARC_W'(1)] <= res_rd + bott_q;
			default: ;
		endcase
		if (res_re) begin
			res_rd <= res_mem[res_ra];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ARC_RD: next_mem[arc_k] <= ARC_NONE;
			OP_ARC_WR: begin
				if (hv_q[u_node]) begin
					next_mem[tail_rd[ARC_W-1:0]] <= arc_cnt_q;
				end
			end
			default: ;
		endcase
		if (next_re) begin
			next_rd <= next_mem[next_ra];
		end
	end

	// Per-node list ends
	always_ff @(posedge clk) begin
		if (cmd.op == OP_ARC_WR) begin
			if (!hv_q[u_node]) begin
				head_mem[u_node] <= arc_cnt_q;
			end
			tail_mem[u_node] <= arc_cnt_q;
		end
		if (head_re) begin
			head_rd <= head_mem[node_ra];
			tail_rd <= tail_mem[node_ra];
		end
	end

	// Node levels
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_BFS_INIT: lvl_mem[src_q] <= '0;
			OP_BFS_CHK: begin
				if (bfs_take) begin
					lvl_mem[dest_rd] <= xl_q + LVL_W'(1);
				end
			end
			default: ;
		endcase
		if (lvl_re) begin
			lvl_rd <= lvl_mem[lvl_ra];
		end
	end

	// Resume arcs
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_DFS_FOUND: resm_mem[node_q] <= a_q;
			OP_DFS_STOP:  resm_mem[node_q] <= ARC_NONE;
			OP_DFS_ADV3:  resm_mem[node_q] <= next_rd;
			default: ;
		endcase
		if (head_re) begin
			resm_rd <= resm_mem[node_q];
		end
	end

	// Search queue
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_BFS_INIT: queue_mem[0] <= src_q;
			OP_BFS_CHK: begin
				if (bfs_take) begin
					queue_mem[wr_q[NODE_W-1:0]] <= dest_rd;
				end
			end
			default: ;
		endcase
		if (cmd.op == OP_BFS_POP) begin
			queue_rd <= queue_mem[rd_q[NODE_W-1:0]];
		end
	end

	// Path stack
	always_ff @(posedge clk) begin
		if (cmd.op == OP_DFS_FOUND && !depth_full) begin
			stack_mem[depth_q[NODE_W-1:0]] <= a_q[ARC_W-1:0];
		end
		if (stack_re) begin
			stack_rd <= stack_mem[stack_ra];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= SOURCE_RESET;
			dst_q <= SINK_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SOURCE: src_q <= cfg_data;
				CFG_SINK:   dst_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control state: counters, valid bits, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arc_cnt_q   <= '0;
			ovf_q       <= 1'b0;
			j_q         <= '0;
			hv_q        <= '0;
			lv_q        <= '0;
			rv_q        <= '0;
			rd_q        <= '0;
			wr_q        <= '0;
			depth_q     <= '0;
			i_q         <= '0;
			total_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (!result_stall && cmd.op != OP_FIN) begin
				res_valid_q <= 1'b0;
			end
			if (cmd.take) begin
				j_q <= '0;
			end
			case (cmd.op)
				OP_OVF: ovf_q <= 1'b1;
				OP_ARC_WR: begin
					hv_q[u_node] <= 1'b1;
					arc_cnt_q    <= arc_cnt_q + ARCP_W'(1);
					j_q          <= j_q + 2'd1;
				end
				OP_BFS_INIT: begin
					lv_q <= NODES'(1) << src_q;
					rd_q <= '0;
					wr_q <= DEPTH_W'(1);
				end
				OP_BFS_POP: rd_q <= rd_q + DEPTH_W'(1);
				OP_BFS_CHK: begin
					if (bfs_take) begin
						lv_q[dest_rd] <= 1'b1;
						wr_q          <= wr_q + DEPTH_W'(1);
					end
				end
				OP_DFS_INIT: begin
					rv_q    <= '0;
					depth_q <= '0;
				end
				OP_DFS_FOUND: begin
					rv_q[node_q] <= 1'b1;
					if (!depth_full) begin
						depth_q <= depth_q + DEPTH_W'(1);
					end
				end
				OP_DFS_STOP, OP_DFS_ADV3: rv_q[node_q] <= 1'b1;
				OP_DFS_POP: depth_q <= depth_dec;
				OP_AUG_INIT: i_q <= '0;
				OP_AM_CMP: i_q <= sts.i_last ? '0 : i_inc;
				OP_AU_ADD: i_q <= i_inc;
				OP_AUG_END: begin
					total_q <= total_q + FLOW_W'(bott_q);
					depth_q <= '0;
				end
				OP_FIN: begin
					res_valid_q <= 1'b1;
					hv_q        <= '0;
					arc_cnt_q   <= '0;
					ovf_q       <= 1'b0;
					total_q     <= '0;
				end
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			f_q    <= from_node;
			t_q    <= to_node;
			cap_q  <= capacity;
			last_q <= last;
		end
		case (cmd.op)
			OP_BFS_X:    x_q <= queue_rd;
			OP_BFS_HEAD: begin
				xl_q <= lvl_rd;
				a_q  <= hv_q[x_q] ? head_rd : ARC_NONE;
			end
			OP_BFS_CHK:  a_q <= next_rd;
			OP_DFS_INIT: node_q <= src_q;
			OP_DFS_RES: begin
				nlvl_q <= lvl_rd;
				a_q    <= node_arc;
			end
			OP_DFS_CMP: begin
				if (!found) begin
					a_q <= next_rd;
				end
			end
			OP_DFS_FOUND: begin
				if (!depth_full) begin
					node_q <= dest_rd;
				end
			end
			OP_DFS_POP3: node_q <= dest_rd;
			OP_AUG_INIT: bott_q <= '1;
			OP_AM_CMP: begin
				if (res_rd < bott_q) begin
					bott_q <= res_rd;
				end
			end
			OP_AU_A:    a_q <= {1'b0, stack_rd};
			OP_AUG_END: node_q <= src_q;
			OP_FIN: begin
				flow_q <= total_q;
				drop_q <= ovf_q;
			end
			default: ;
		endcase
	end

	// Status to the controller
	always_comb begin
		sts.arc_full    = (arc_cnt_q > ARC_LIMIT);
		sts.last        = last_q;
		sts.src_eq_dst  = (src_q == dst_q);
		sts.j_last      = (j_q == 2'd3);
		sts.q_empty     = (rd_q == wr_q);
		sts.dst_reached = lv_q[dst_q];
		sts.a_none      = (a_q == ARC_NONE);
		sts.at_dst      = (node_q == dst_q);
		sts.found       = found;
		sts.depth_full  = depth_full;
		sts.depth_zero  = (depth_q == '0);
		sts.cur_none    = (node_arc == ARC_NONE);
		sts.i_last      = (i_inc == depth_q);
		sts.out_busy    = res_valid_q && result_stall;
	end

	assign result_valid  = res_valid_q;
	assign max_flow      = flow_q;
	assign edges_dropped = drop_q;

endmodule

// File: tb/max_flow_dinic_test.sv
`timescale 1ns / 100ps

module max_flow_dinic_test;
	import mfd_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SOURCE;
	logic [NODE_W-1:0]    cfg_data = '0;
	logic                 edge_valid = 1'b0;
	logic                 edge_stall;
	logic [NODE_W-1:0]    from_node = '0;
	logic [NODE_W-1:0]    to_node = '0;
	logic [CAP_W-1:0]     capacity = '0;
	logic                 last = 1'b0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [FLOW_W-1:0]    max_flow;
	logic                 edges_dropped;

	max_flow_dinic dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: own copy of graph tables and registers
	logic [NODE_W-1:0] src_reg, dst_reg;
	int unsigned dest_t[ARCS], resid_t[ARCS], next_t[ARCS];
	int unsigned head_t[NODES], tail_t[NODES], lvl_t[NODES], resume_t[NODES];
	int unsigned queue_t[NODES], stack_t[NODES];
	int unsigned arcs_used;
	bit          dropped_flag;

	typedef struct {
		logic [FLOW_W-1:0] flow;
		logic              dropped;
	} flow_result_t;
	flow_result_t flows_due[$];

	int  errors = 0;
	int  cycles = 0;
	bit  quiet = 1'b0;

	function automatic void graph_clear();
		for (int n = 0; n < NODES; n++) begin
			head_t[n] = ARCS;
			tail_t[n] = ARCS;
			lvl_t[n] = 32'hFFFF;
		end
		arcs_used = 0;
		dropped_flag = 1'b0;
	endfunction

	function automatic void add_arc(int unsigned u, int unsigned w, int unsigned c);
		int unsigned k;
		k = arcs_used;
		dest_t[k] = w;
		resid_t[k] = c;
		next_t[k] = ARCS;
		if (head_t[u] == ARCS) head_t[u] = k;
		else next_t[tail_t[u]] = k;
		tail_t[u] = k;
		arcs_used = k + 1;
	endfunction

	function automatic bit levels_reach(int unsigned s, int unsigned d);
		int unsigned rd, wr, x, a, y;
		rd = 0;
		wr = 0;
		for (int n = 0; n < NODES; n++) lvl_t[n] = 32'hFFFF;
		lvl_t[s] = 0;
		queue_t[wr++] = s;
		while (rd < wr) begin
			x = queue_t[rd++];
			a = head_t[x];
			while (a != ARCS && a < arcs_used) begin
				y = dest_t[a];
				if (lvl_t[y] == 32'hFFFF && resid_t[a] > 0 && wr < NODES) begin
					lvl_t[y] = lvl_t[x] + 1;
					queue_t[wr++] = y;
				end
				a = next_t[a];
			end
		end
		return lvl_t[d] != 32'hFFFF;
	endfunction

	function automatic longint unsigned push_blocking(int unsigned s, int unsigned d);
		longint unsigned sum;
		int unsigned depth, node, bott, a;
		sum = 0;
		depth = 0;
		node = s;
		for (int n = 0; n < NODES; n++) resume_t[n] = head_t[n];
		forever begin
			if (node == d) begin
				bott = 2147483647;
				for (int i = 0; i < depth; i++)
					if (resid_t[stack_t[i]] < bott) bott = resid_t[stack_t[i]];
				for (int i = 0; i < depth; i++) begin
					resid_t[stack_t[i]] -= bott;
					resid_t[stack_t[i] ^ 1] += bott;
				end
				sum += bott;
				depth = 0;
				node = s;
				continue;
			end
			a = resume_t[node];
			while (a != ARCS && a < arcs_used) begin
				if (lvl_t[dest_t[a]] == lvl_t[node] + 1 && resid_t[a] > 0) break;
				a = next_t[a];
			end
			if (a >= arcs_used) a = ARCS;
			resume_t[node] = a;
			if (a != ARCS && depth < NODES) begin
				stack_t[depth++] = a;
				node = dest_t[a];
				continue;
			end
			if (depth == 0) break;
			depth--;
			node = dest_t[stack_t[depth] ^ 1];
			if (resume_t[node] != ARCS) resume_t[node] = next_t[resume_t[node]];
		end
		return sum;
	endfunction

	// Work out what one edge request does; queue a result on the closing edge
	function automatic void predict_edge(int unsigned f, int unsigned t,
			int unsigned c, bit fin);
		longint unsigned sum;
		flow_result_t r;
		int unsigned fm, tm, cm;
		sum = 0;
		fm = f % NODES;
		tm = t % NODES;
		cm = c & 32'h00FF_FFFF;
		if (arcs_used + 4 <= ARCS) begin
			add_arc(fm, tm, cm);
			add_arc(tm, fm, 0);
			add_arc(tm, fm, cm);
			add_arc(fm, tm, 0);
		end else begin
			dropped_flag = 1'b1;
		end
		if (!fin) return;
		if (src_reg != dst_reg)
			while (levels_reach(src_reg, dst_reg)) sum += push_blocking(src_reg, dst_reg);
		r.flow = sum[FLOW_W-1:0];
		r.dropped = dropped_flag;
		flows_due = {flows_due, r};
		graph_clear();
	endfunction

	task automatic report_mismatch(string what, longint unsigned exp_v, longint unsigned got_v);
		$display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
		errors++;
	endtask

	// Result checker
	always @(posedge clk) begin
		flow_result_t r;
		if (arst_n && result_valid && !result_stall) begin
			if (flows_due.size() == 0) begin
				report_mismatch("unexpected result, flow", 0, max_flow);
			end else begin
				r = flows_due.pop_front();
				if (max_flow !== r.flow) report_mismatch("max_flow", r.flow, max_flow);
				if (edges_dropped !== r.dropped)
					report_mismatch("edges_dropped", r.dropped, edges_dropped);
			end
		end
	end

	// Receiver stall bursts
	initial begin
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_edge(int unsigned f, int unsigned t, int unsigned c, bit fin);
		bit stalled;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			edge_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		edge_valid <= 1'b1;
		from_node <= f[NODE_W-1:0];
		to_node <= t[NODE_W-1:0];
		capacity <= c[CAP_W-1:0];
		last <= fin;
		predict_edge(f, t, c, fin);
		// edge_stall only moves at a rising edge, so sample it at the falling edge before
		do begin
			@(negedge clk);
			stalled = edge_stall;
			@(posedge clk);
		end while (stalled);
	endtask

	task automatic drain_results();
		edge_valid <= 1'b0;
		while (flows_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Registers are written only once all results have come back
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[NODE_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_SOURCE) src_reg = val[NODE_W-1:0];
		else dst_reg = val[NODE_W-1:0];
	endtask

	task automatic test_directed();
		// single edge at full capacity between reset source and sink
		send_edge(65, 90, 24'hFFFFFF, 1);
		// zero capacity, reversed endpoints
		send_edge(90, 65, 0, 1);
		// two paths, one bottlenecked, plus a self loop
		send_edge(65, 1, 10, 0);
		send_edge(1, 90, 3, 0);
		send_edge(7, 7, 5, 0);
		send_edge(65, 2, 4, 0);
		send_edge(2, 90, 9, 1);
		// sink unreachable
		send_edge(65, 3, 100, 1);
		// extreme node ids
		write_reg(CFG_SOURCE, 0);
		write_reg(CFG_SINK, 127);
		send_edge(0, 127, 24'hAAAAAA, 0);
		send_edge(127, 0, 24'h555555, 0);
		send_edge(0, 64, 24'hFFFFFF, 0);
		send_edge(64, 127, 24'hFFFFFF, 1);
		// source equals sink, then source 127 and sink 0 apart
		write_reg(CFG_SINK, 0);
		send_edge(0, 5, 8, 0);
		send_edge(5, 0, 8, 1);
		write_reg(CFG_SOURCE, 127);
		write_reg(CFG_SINK, 0);
		send_edge(127, 0, 1, 1);
	endtask

	// More edges than the table holds
	task automatic test_overflow();
		write_reg(CFG_SOURCE, 10);
		write_reg(CFG_SINK, 20);
		for (int i = 0; i < 262; i++)
			send_edge($urandom_range(8, 22), $urandom_range(8, 22),
				$urandom_range(0, 1000), i == 261);
		// the next load starts from a clean table
		send_edge(10, 20, 77, 1);
	endtask

	task automatic test_random();
		int unsigned pool[8];
		int unsigned n, c, items;
		items = 0;
		while (items < 420) begin
			if ($urandom_range(0, 3) == 0) begin
				write_reg(CFG_SOURCE, $urandom_range(0, 127));
				write_reg(CFG_SINK, ($urandom_range(0, 9) == 0) ? src_reg :
					$urandom_range(0, 127));
			end
			if (items > 360) quiet = 1'b1;
			pool[0] = src_reg;
			pool[1] = dst_reg;
			for (int i = 2; i < 8; i++) pool[i] = $urandom_range(0, 127);
			n = $urandom_range(1, 24);
			for (int i = 0; i < n; i++) begin
				c = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 50);
				if ($urandom_range(0, 9) == 0)
					send_edge($urandom_range(0, 127), $urandom_range(0, 127), c, i == n - 1);
				else
					send_edge(pool[$urandom_range(0, 7)], pool[$urandom_range(0, 7)],
						c, i == n - 1);
				items++;
			end
		end
	endtask

	initial begin
		src_reg = SOURCE_RESET;
		dst_reg = SINK_RESET;
		graph_clear();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_random();
		drain_results();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
